FILE: design/mmgn_pkg.sv
// ----------------------------------------------------------------------------
// mmgn_pkg
// Shared types and constants for the min/max greyscale normalizer.
// ----------------------------------------------------------------------------
package mmgn_pkg;

  localparam int CMD_W  = 2;
  localparam int ELEV_W = 16;
  localparam int GREY_W = 8;

  // Dividend width: 511 * 65535 fits in 25 bits.
  localparam int DIVIDEND_W = 25;
  localparam int DIV_STEPS  = GREY_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic clear_en;
    logic emit_start;
    logic range_en;
    logic scale_en;
    logic div_start;
    logic result_write;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_avail;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/min_max_greyscale_normalize.sv
// ----------------------------------------------------------------------------
// min_max_greyscale_normalize
// Stores one frame of signed elevation samples and emits them as grey levels.
// ----------------------------------------------------------------------------
// The slave channel carries requests: a load appends a sample to the frame and
// updates the running minimum and maximum, an emit asks for the next stored
// sample as an 8-bit grey level, and a clear starts a new frame. Only an emit
// with a sample left produces a result on the master channel; tlast marks the
// final stored sample of the frame. Loads, clears, unused codes and emits with
// nothing left leave the controller idle, so they can be accepted back to back.
// An emit that produces a result occupies the block: the cycle that accepts it
// also reads the sample store, then the read state takes the range, the scale
// state clamps the offset, the start state loads the divider, the bit-serial
// divider forms the rounded quotient, and the divide state then writes it into
// the output register. The result shows on the master channel in the next
// cycle, which is also the first in which a new request is accepted.
// A finished result waits in the output register while the receiver stalls,
// and requests that need no division keep being accepted meanwhile; a new
// result waits in the divider until the register is free.
// Reset empties the frame and clears both extremes; the sample store itself
// is not cleared, since only entries written in the current frame are read.
// ----------------------------------------------------------------------------
module min_max_greyscale_normalize
  import mmgn_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [1:0] cmd, [17:2] elevation, [23:18] zero
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [7:0] grey
  output logic        m_tlast
);

  ctrl_cmd_t                cmd;
  dp_status_t               status;
  logic [CMD_W-1:0]         op;
  logic signed [ELEV_W-1:0] elevation;

  // Unpack the request fields.
  assign op        = s_tdata[CMD_W-1:0];
  assign elevation = s_tdata[CMD_W+ELEV_W-1:CMD_W];

  // The controller owns the handshake and sequences each emit.
  mmgn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .op       (op),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the frame, the extremes, the divider and the result.
  mmgn_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .elevation (elevation),
    .status    (status),
    .m_ready   (m_tready),
    .m_valid   (m_tvalid),
    .m_grey    (m_tdata),
    .m_last    (m_tlast)
  );

endmodule

FILE: design/mmgn_div.sv
// ----------------------------------------------------------------------------
// mmgn_div
// Restoring divider producing the rounded 8-bit grey level, one bit a cycle.
// ----------------------------------------------------------------------------
module mmgn_div
  import mmgn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ELEV_W-1:0] num,
  input  logic [ELEV_W-1:0] den,
  output logic              done,
  output logic [GREY_W-1:0] quotient
);

  logic                  busy;
  logic [STEP_CNT_W-1:0] steps;
  logic [ELEV_W:0]       rem;
  logic [ELEV_W:0]       divisor;
  logic [GREY_W-1:0]     bits;
  logic [DIVIDEND_W-1:0] dividend;
  logic [ELEV_W+1:0]     trial;
  logic                  fits;

  // Rounded half up: (2*255*num + den) / (2*den), with 510*num = 512*num - 2*num.
  assign dividend = ({num, 9'd0} - {8'd0, num, 1'b0}) + DIVIDEND_W'(den);
  assign trial    = {rem, bits[GREY_W-1]};
  assign fits     = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      steps <= steps - STEP_CNT_W'(1);
      if (steps == STEP_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= dividend[DIVIDEND_W-1:GREY_W];
      bits    <= dividend[GREY_W-1:0];
      divisor <= {den, 1'b0};
    end else if (busy) begin
      if (fits) begin
        rem <= (ELEV_W+1)'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[ELEV_W:0];
      end
      bits <= {bits[GREY_W-2:0], fits};
    end
  end

  assign done     = !busy;
  assign quotient = bits;

endmodule

FILE: design/mmgn_datapath.sv
// ----------------------------------------------------------------------------
// mmgn_datapath
// Sample store, frame counters, running extremes, scaling and result register.
// ----------------------------------------------------------------------------
module mmgn_datapath
  import mmgn_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  input  logic signed [ELEV_W-1:0] elevation,
  output dp_status_t               status,
  input  logic                     m_ready,
  output logic                     m_valid,
  output logic [GREY_W-1:0]        m_grey,
  output logic                     m_last
);

  localparam int CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  logic [ELEV_W-1:0]        store [SAMPLE_DEPTH];
  logic [CW-1:0]            sample_count;
  logic [CW-1:0]            read_position;
  logic signed [ELEV_W-1:0] smallest;
  logic signed [ELEV_W-1:0] largest;

  logic signed [ELEV_W-1:0] rd_data;
  logic                     last_flag;
  logic [ELEV_W-1:0]        span;
  logic                     flat;
  logic [ELEV_W-1:0]        num;
  logic                     full;
  logic [ELEV_W:0]          span_full;
  logic [ELEV_W:0]          diff;
  logic                     div_done;
  logic [GREY_W-1:0]        quotient;

  assign full      = sample_count == CW'(SAMPLE_DEPTH);
  assign span_full = {largest[ELEV_W-1], largest} - {smallest[ELEV_W-1], smallest};
  assign diff      = {rd_data[ELEV_W-1], rd_data} - {smallest[ELEV_W-1], smallest};

  // Sample store: written in load order, read at the emit pointer.
  always_ff @(posedge clk) begin
    if (cmd.load_en && !full) begin
      store[sample_count[AW-1:0]] <= elevation;
    end
    if (cmd.emit_start) begin
      rd_data   <= store[read_position[AW-1:0]];
      last_flag <= (read_position + CW'(1)) == sample_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      read_position <= '0;
      smallest      <= '0;
      largest       <= '0;
    end else if (cmd.clear_en) begin
      sample_count  <= '0;
      read_position <= '0;
      smallest      <= '0;
      largest       <= '0;
    end else begin
      if (cmd.load_en && !full) begin
        sample_count <= sample_count + CW'(1);
        if (sample_count == '0) begin
          smallest <= elevation;
          largest  <= elevation;
        end else if (elevation > largest) begin
          largest <= elevation;
        end else if (elevation < smallest) begin
          smallest <= elevation;
        end
      end
      if (cmd.emit_start) begin
        read_position <= read_position + CW'(1);
      end
    end
  end

  // Range and clamped offset of the sample being scaled.
  always_ff @(posedge clk) begin
    if (cmd.range_en) begin
      span <= span_full[ELEV_W-1:0];
      flat <= largest <= smallest;
    end
    if (cmd.scale_en) begin
      if (diff[ELEV_W] || diff[ELEV_W-1:0] > span) begin
        num <= span;
      end else begin
        num <= diff[ELEV_W-1:0];
      end
    end
  end

  mmgn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (num),
    .den      (span),
    .done     (div_done),
    .quotient (quotient)
  );

  // Result register: holds a finished result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.result_write) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_write) begin
      m_grey <= flat ? '0 : quotient;
      m_last <= last_flag;
    end
  end

  assign status.emit_avail = read_position < sample_count;
  assign status.div_done   = div_done;
  assign status.out_free   = !m_valid || m_ready;

endmodule

FILE: design/mmgn_ctrl.sv
// ----------------------------------------------------------------------------
// mmgn_ctrl
// Controller sequencing request acceptance and the scaling of one sample.
// ----------------------------------------------------------------------------
module mmgn_ctrl
  import mmgn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] op,
  output logic             in_ready,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SCALE = 5'b00100,
    S_START = 5'b01000,
    S_DIV   = 5'b10000
  } state_t;

  state_t    state;
  state_t    state_next;
  logic      accept;
  cmd_code_t code;

  assign code     = cmd_code_t'(op);
  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd              = '0;
    cmd.load_en      = accept && code == CMD_LOAD;
    cmd.clear_en     = accept && code == CMD_CLEAR;
    cmd.emit_start   = accept && code == CMD_EMIT && status.emit_avail;
    cmd.range_en     = state == S_READ;
    cmd.scale_en     = state == S_SCALE;
    cmd.div_start    = state == S_START;
    cmd.result_write = state == S_DIV && status.div_done && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.emit_start) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_SCALE;
      S_SCALE: state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (cmd.result_write) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: tb/sv/min_max_greyscale_normalize_tb.sv
// ----------------------------------------------------------------------------
// min_max_greyscale_normalize_tb
// Self-checking bench for the min/max grey-level normalizer.
// ----------------------------------------------------------------------------
// Requests go into the slave channel and the grey levels that come out of the
// master channel are checked against a predictor of the frame kept in the
// bench. A short table of directed requests comes first, then a phase in
// which the result side holds off for a long stretch, and last a random mix
// of frames with some noise between them. Both sides idle at random between
// requests.
// ----------------------------------------------------------------------------
module min_max_greyscale_normalize_tb
  import mmgn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SAMPLE_DEPTH  = 4096;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int          DIRECTED_ROWS = 28;

  // One expected result: the grey level and the end-of-frame mark.
  typedef struct packed {
    logic [GREY_W-1:0] grey;
    logic              last;
  } grey_level_t;

  // One row of the directed table. When known is set, the expected result
  // is taken from the row instead of from the predictor.
  typedef struct packed {
    cmd_code_t         cmd;
    logic [ELEV_W-1:0] elev;
    bit                known;
    grey_level_t       lvl;
  } request_row_t;

  // How the samples of a random frame are spread.
  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_TIGHT,
    SPREAD_EXTREME,
    SPREAD_MEDIUM
  } spread_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [1:0] cmd, [17:2] elevation, [23:18] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] grey
  logic        m_tlast;

  min_max_greyscale_normalize #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Predicted state of the frame.
  logic [ELEV_W-1:0] frame_samples [SAMPLE_DEPTH];
  int unsigned       frame_count;
  int unsigned       emit_pos;
  int                frame_min;
  int                frame_max;

  grey_level_t expected_levels [$];
  int unsigned error_count;
  bit          no_idle;        // when set, neither side idles
  bit          hold_results;   // asks the result side for one long hold-off

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous limit: the slowest correct run stays far below this.
  initial begin
    #20_000_000;
    $display("min_max_greyscale_normalize: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned idle_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // 255 * (v - min) / (max - min), rounded half up; a flat frame gives 0.
  function automatic logic [GREY_W-1:0] scale_to_grey(input int v);
    int span;
    int offset;
    if (frame_max <= frame_min) return '0;
    span   = frame_max - frame_min;
    offset = v - frame_min;
    if (offset > span) offset = span;
    return GREY_W'((510 * offset + span) / (2 * span));
  endfunction

  // Applies one accepted request to the predicted frame. produced tells
  // whether a result comes out; changed tells whether the request did
  // anything at all, so that ignored requests are not counted as stimulus.
  function automatic void apply_request(input cmd_code_t cmd, input logic [ELEV_W-1:0] elev,
                                        output bit produced, output bit changed,
                                        output grey_level_t lvl);
    int v;
    produced = 1'b0;
    changed  = 1'b0;
    lvl      = '0;
    case (cmd)
      CMD_LOAD: begin
        if (frame_count < SAMPLE_DEPTH) begin
          v = int'($signed(elev));
          frame_samples[frame_count] = elev;
          // The first sample of a frame seeds both extremes.
          if (frame_count == 0) begin
            frame_min = v;
            frame_max = v;
          end else if (v > frame_max) begin
            frame_max = v;
          end else if (v < frame_min) begin
            frame_min = v;
          end
          frame_count++;
          changed = 1'b1;
        end
      end
      CMD_EMIT: begin
        if (emit_pos < frame_count) begin
          lvl.grey = scale_to_grey(int'($signed(frame_samples[emit_pos])));
          lvl.last = (emit_pos + 1 == frame_count);
          emit_pos++;
          produced = 1'b1;
          changed  = 1'b1;
        end
      end
      CMD_CLEAR: begin
        frame_count = 0;
        emit_pos    = 0;
        frame_min   = 0;
        frame_max   = 0;
        changed     = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ELEV_W-1:0] pick_elevation(input spread_t spread,
                                                       input logic [ELEV_W-1:0] base);
    case (spread)
      SPREAD_FULL:  return ELEV_W'($urandom);
      SPREAD_TIGHT: return base + ELEV_W'($urandom_range(0, 3));
      SPREAD_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return ELEV_W'($urandom);
        endcase
      end
      default:      return base + ELEV_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one request and waits until it is accepted. s_tvalid is only
  // lowered when a gap follows, so it never gets two assignments in one step.
  // The prediction is made at the edge that accepts the request.
  task automatic send_request(input cmd_code_t cmd, input logic [ELEV_W-1:0] elev,
                              input bit known, input grey_level_t known_lvl,
                              output bit changed);
    int unsigned gap;
    bit          produced;
    grey_level_t lvl;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, elev, cmd};
    do @(posedge clk); while (!s_tready);
    apply_request(cmd, elev, produced, changed, lvl);
    if (produced) expected_levels.push_back(known ? known_lvl : lvl);
  endtask

  // Result side. It runs cycle by cycle so that m_tready gets exactly one
  // assignment per edge. A long hold-off, when asked for, is counted here.
  initial begin : result_side
    int unsigned wait_left;
    int unsigned hold_left;
    grey_level_t want;
    wait_left = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_levels.size() == 0) begin
          flag_mismatch("grey level with nothing expected", m_tdata, -1);
        end else begin
          want = expected_levels.pop_front();
          if (m_tdata !== want.grey) flag_mismatch("grey", m_tdata, want.grey);
          if (m_tlast !== want.last) flag_mismatch("last", m_tlast, want.last);
        end
        wait_left = idle_gap();
      end
      if (hold_results) begin
        hold_left    = HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      m_tready <= (hold_left == 0) && (wait_left == 0);
    end
  end

  initial begin : stimulus
    request_row_t      rows [DIRECTED_ROWS];
    bit                changed;
    int unsigned       random_items;
    int unsigned       frame_len;
    int unsigned       loaded;
    int unsigned       emitted;
    spread_t           spread;
    logic [ELEV_W-1:0] base;

    s_tvalid     = 1'b0;
    s_tdata      = '0;
    rst          = 1'b1;
    error_count  = 0;
    no_idle      = 1'b0;
    hold_results = 1'b0;
    random_items = 0;
    frame_count  = 0;
    emit_pos     = 0;
    frame_min    = 0;
    frame_max    = 0;

    // Directed requests. Results that can be read off directly are typed
    // in; the rest come from the predictor.
    rows = '{
      // Emit straight after reset: nothing stored, so no result.
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      // The unused code is ignored.
      '{CMD_NONE,  16'h5A5A, 1'b0, '{8'd0,   1'b0}},
      // Both extremes of the elevation range and a middle value.
      '{CMD_LOAD,  16'h8000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_LOAD,  16'h7FFF, 1'b0, '{8'd0,   1'b0}},
      '{CMD_LOAD,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b1, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'hFFFF, 1'b1, '{8'd255, 1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      // Everything emitted: no result.
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_CLEAR, 16'hFFFF, 1'b0, '{8'd0,   1'b0}},
      // Emit on a freshly cleared frame: no result.
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      // Flat frame gives zero.
      '{CMD_LOAD,  16'h0064, 1'b0, '{8'd0,   1'b0}},
      '{CMD_LOAD,  16'h0064, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b1, '{8'd0,   1'b0}},
      // A load in the middle of emission widens the range for later emits.
      '{CMD_LOAD,  16'h00C8, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b1, '{8'd255, 1'b1}},
      '{CMD_CLEAR, 16'h0000, 1'b0, '{8'd0,   1'b0}},
      // A single negative sample is a flat frame and the last one.
      '{CMD_LOAD,  16'hFFFB, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b1, '{8'd0,   1'b1}},
      '{CMD_CLEAR, 16'h0000, 1'b0, '{8'd0,   1'b0}},
      // Range of two: the middle sample lands on a half and rounds up.
      '{CMD_LOAD,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_LOAD,  16'h0002, 1'b0, '{8'd0,   1'b0}},
      '{CMD_LOAD,  16'h0001, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_EMIT,  16'h0000, 1'b0, '{8'd0,   1'b0}},
      '{CMD_NONE,  16'hFFFF, 1'b0, '{8'd0,   1'b0}}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].cmd, rows[i].elev, rows[i].known, rows[i].lvl,
                                   changed);

    // Back pressure: the result side holds off while emits keep coming, so
    // the output register and the divider fill up and requests stall.
    send_request(CMD_CLEAR, 16'h0000, 1'b0, '0, changed);
    repeat (8) send_request(CMD_LOAD, ELEV_W'($urandom), 1'b0, '0, changed);
    no_idle      = 1'b1;
    hold_results = 1'b1;
    repeat (12) send_request(CMD_EMIT, ELEV_W'($urandom), 1'b0, '0, changed);
    no_idle = 1'b0;

    // Random part: mostly whole frames with random content, emits mixed in
    // while loading, and now and then a burst of arbitrary requests.
    while (random_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          send_request(cmd_code_t'($urandom_range(0, 3)), ELEV_W'($urandom), 1'b0, '0,
                       changed);
          random_items += changed;
        end
      end else begin
        spread    = spread_t'($urandom_range(0, 3));
        base      = ELEV_W'($urandom);
        frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 24);
        loaded    = 0;
        emitted   = 0;
        send_request(CMD_CLEAR, ELEV_W'($urandom), 1'b0, '0, changed);
        random_items += changed;
        while (loaded < frame_len) begin
          send_request(CMD_LOAD, pick_elevation(spread, base), 1'b0, '0, changed);
          random_items += changed;
          loaded++;
          if ($urandom_range(0, 3) == 0 && emitted < loaded) begin
            send_request(CMD_EMIT, ELEV_W'($urandom), 1'b0, '0, changed);
            random_items += changed;
            emitted++;
          end
        end
        while (emitted < frame_len) begin
          send_request(CMD_EMIT, ELEV_W'($urandom), 1'b0, '0, changed);
          random_items += changed;
          emitted++;
        end
        // Sometimes one emit too many, which must give nothing.
        if ($urandom_range(0, 1) == 1) send_request(CMD_EMIT, 16'h0000, 1'b0, '0, changed);
      end
    end
    no_idle = 1'b0;

    s_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("min_max_greyscale_normalize: match");
    end else begin
      $display("min_max_greyscale_normalize: mismatch");
    end
    $finish;
  end

endmodule

FILE: min_max_greyscale_normalize.f
design/mmgn_pkg.sv
design/mmgn_div.sv
design/mmgn_datapath.sv
design/mmgn_ctrl.sv
design/min_max_greyscale_normalize.sv
tb/sv/min_max_greyscale_normalize_tb.sv
